>>> rtl/lcsd_pkg.sv
// Shared constants, types and state codes of the diagonal LCS length engine.
package lcsd_pkg;

	localparam int MAX_LEN      = 256;
	localparam int MAX_ALPHABET = 16;

	localparam int OP_W      = 2;
	localparam int SYM_W     = 5;
	localparam int CFG_W     = 5;
	localparam int OUT_LEN_W = 9;

	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int ADDR_W  = $clog2(MAX_LEN);
	localparam int POS_W   = $clog2(MAX_LEN + 2);
	localparam int ALPHA_W = $clog2(MAX_ALPHABET);
	localparam int AC_W    = $clog2(MAX_ALPHABET + 1);
	localparam int CMP_W   = SYM_W + AC_W;
	localparam int TBL_AW  = ALPHA_W + CNT_W;
	localparam int TBL_DEPTH = 1 << TBL_AW;

	localparam logic [POS_W-1:0] NO_MATCH = POS_W'(MAX_LEN + 1);

	typedef enum logic [OP_W-1:0] {
		OP_LOAD_A  = 2'd0,
		OP_LOAD_B  = 2'd1,
		OP_COMPUTE = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	typedef struct packed {
		logic [CNT_W-1:0] m;
		logic [CNT_W-1:0] n;
		logic [AC_W-1:0]  alpha;
	} job_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [POS_W-1:0]  data;
	} diag_wr_t;

	typedef struct packed {
		logic              en;
		logic [TBL_AW-1:0] addr;
		logic [POS_W-1:0]  data;
	} tbl_wr_t;

	typedef enum logic [2:0] {
		BLD_IDLE,
		BLD_CLEAR,
		BLD_INIT,
		BLD_RUN,
		BLD_DRAIN,
		BLD_DONE
	} bld_state_t;

	typedef enum logic [1:0] {
		SW_IDLE,
		SW_TBL,
		SW_EVAL,
		SW_DONE
	} sw_state_t;

	typedef enum logic [1:0] {
		TOP_IDLE,
		TOP_BUILD,
		TOP_SWEEP,
		TOP_DONE
	} top_state_t;

endpackage

>>> rtl/lcsd_ram.sv
// Generic simple dual-port RAM with registered read.
module lcsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/lcsd_build.sv
// Diagonal store clear and backward next-occurrence table build.
module lcsd_build (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  lcsd_pkg::job_t             job,
	input  logic [lcsd_pkg::SYM_W-1:0] b_rdata,
	output logic [lcsd_pkg::ADDR_W-1:0] b_raddr,
	output lcsd_pkg::tbl_wr_t          tbl_wr,
	output lcsd_pkg::diag_wr_t         diag_wr,
	output logic                       done
);

	lcsd_pkg::bld_state_t st_q, st_d;

	logic [lcsd_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_m1, cnt_p1;
	logic [lcsd_pkg::AC_W-1:0]  s_q, s_d, s_p1;
	logic [lcsd_pkg::POS_W-1:0] nxt_q, nxt_d, val;
	logic                       v_s1, v_d;
	logic [lcsd_pkg::CNT_W-1:0] p_s1, p_d, p_m1;
	logic                       hit, s_last;

	assign cnt_m1 = cnt_q - lcsd_pkg::CNT_W'(1);
	assign cnt_p1 = cnt_q + lcsd_pkg::CNT_W'(1);
	assign s_p1   = s_q + lcsd_pkg::AC_W'(1);
	assign s_last = (s_p1 == job.alpha);
	assign p_m1   = p_s1 - lcsd_pkg::CNT_W'(1);
	// B[p-1] is symbol s+1: the next occurrence from p-1 is p
	assign hit    = (lcsd_pkg::CMP_W'(b_rdata) == lcsd_pkg::CMP_W'(s_p1));
	assign val    = hit ? lcsd_pkg::POS_W'(p_s1) : nxt_q;
	assign b_raddr = cnt_m1[lcsd_pkg::ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= lcsd_pkg::BLD_IDLE;
			v_s1 <= 1'b0;
		end else begin
			st_q <= st_d;
			v_s1 <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		cnt_q <= cnt_d;
		s_q   <= s_d;
		nxt_q <= nxt_d;
		p_s1  <= p_d;
	end

	always_comb begin
		st_d    = st_q;
		cnt_d   = cnt_q;
		s_d     = s_q;
		nxt_d   = nxt_q;
		v_d     = 1'b0;
		p_d     = p_s1;
		tbl_wr  = '0;
		diag_wr = '0;
		done    = 1'b0;

		// write stage of the backward fill
		if (v_s1) begin
			tbl_wr.en   = 1'b1;
			tbl_wr.addr = {s_q[lcsd_pkg::ALPHA_W-1:0], p_m1};
			tbl_wr.data = val;
			nxt_d       = val;
		end

		case (st_q)
			lcsd_pkg::BLD_IDLE: begin
				if (start) begin
					cnt_d = '0;
					s_d   = '0;
					if (job.m != '0) begin
						st_d = lcsd_pkg::BLD_CLEAR;
					end else if (job.alpha != '0) begin
						st_d = lcsd_pkg::BLD_INIT;
					end else begin
						st_d = lcsd_pkg::BLD_DONE;
					end
				end
			end
			lcsd_pkg::BLD_CLEAR: begin
				diag_wr.en   = 1'b1;
				diag_wr.addr = cnt_q[lcsd_pkg::ADDR_W-1:0];
				diag_wr.data = lcsd_pkg::NO_MATCH;
				cnt_d        = cnt_p1;
				if (cnt_p1 == job.m) begin
					st_d = (job.alpha != '0) ? lcsd_pkg::BLD_INIT : lcsd_pkg::BLD_DONE;
				end
			end
			lcsd_pkg::BLD_INIT: begin
				tbl_wr.en   = 1'b1;
				tbl_wr.addr = {s_q[lcsd_pkg::ALPHA_W-1:0], job.n};
				tbl_wr.data = lcsd_pkg::NO_MATCH;
				nxt_d       = lcsd_pkg::NO_MATCH;
				cnt_d       = job.n;
				if (job.n != '0) begin
					st_d = lcsd_pkg::BLD_RUN;
				end else if (s_last) begin
					st_d = lcsd_pkg::BLD_DONE;
				end else begin
					s_d = s_p1;
				end
			end
			lcsd_pkg::BLD_RUN: begin
				v_d   = 1'b1;
				p_d   = cnt_q;
				cnt_d = cnt_m1;
				if (cnt_q == lcsd_pkg::CNT_W'(1)) begin
					st_d = lcsd_pkg::BLD_DRAIN;
				end
			end
			lcsd_pkg::BLD_DRAIN: begin
				if (s_last) begin
					st_d = lcsd_pkg::BLD_DONE;
				end else begin
					s_d  = s_p1;
					st_d = lcsd_pkg::BLD_INIT;
				end
			end
			lcsd_pkg::BLD_DONE: begin
				done = 1'b1;
				st_d = lcsd_pkg::BLD_IDLE;
			end
			default: begin
				st_d = lcsd_pkg::BLD_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/lcsd_sweep.sv
// Diagonal sweep: least end position in B per length, with early stop.
module lcsd_sweep (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  lcsd_pkg::job_t              job,
	input  logic [lcsd_pkg::SYM_W-1:0]  a_rdata,
	input  logic [lcsd_pkg::POS_W-1:0]  tbl_rdata,
	input  logic [lcsd_pkg::POS_W-1:0]  diag_rdata,
	output logic [lcsd_pkg::ADDR_W-1:0] a_raddr,
	output logic [lcsd_pkg::TBL_AW-1:0] tbl_raddr,
	output logic [lcsd_pkg::ADDR_W-1:0] diag_raddr,
	output lcsd_pkg::diag_wr_t          diag_wr,
	output logic                        done,
	output logic [lcsd_pkg::CNT_W-1:0]  best
);

	lcsd_pkg::sw_state_t st_q, st_d;

	logic [lcsd_pkg::ADDR_W-1:0] i_q, i_d, j_q, j_d, len;
	logic [lcsd_pkg::POS_W-1:0]  pos_q, pos_d, cand, least;
	logic [lcsd_pkg::CNT_W-1:0]  best_q, best_d, len_p1, best_e, i_rem, i_p1c;
	logic                        ok_q, ok_d, sym_ok;
	logic [lcsd_pkg::SYM_W-1:0]  sym_m1;
	logic [lcsd_pkg::SYM_W+lcsd_pkg::ALPHA_W-1:0] sym_wide;
	logic                        fin, stop;

	assign len      = j_q - i_q;
	assign sym_ok   = (a_rdata != '0) &&
	                  (lcsd_pkg::CMP_W'(a_rdata) <= lcsd_pkg::CMP_W'(job.alpha));
	assign sym_m1   = a_rdata - lcsd_pkg::SYM_W'(1);
	assign sym_wide = {{lcsd_pkg::ALPHA_W{1'b0}}, sym_m1};
	assign cand     = ok_q ? tbl_rdata : lcsd_pkg::NO_MATCH;
	assign least    = (diag_rdata < cand) ? diag_rdata : cand;
	assign len_p1   = lcsd_pkg::CNT_W'(len) + lcsd_pkg::CNT_W'(1);
	assign i_rem    = job.m - lcsd_pkg::CNT_W'(i_q);
	assign i_p1c    = lcsd_pkg::CNT_W'(i_q) + lcsd_pkg::CNT_W'(1);

	// address follows the next value of j, so A[j] is on rdata in SW_TBL
	assign a_raddr    = j_d;
	assign tbl_raddr  = {sym_wide[lcsd_pkg::ALPHA_W-1:0], pos_q[lcsd_pkg::CNT_W-1:0]};
	assign diag_raddr = len;
	assign best       = best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= lcsd_pkg::SW_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q    <= i_d;
		j_q    <= j_d;
		pos_q  <= pos_d;
		best_q <= best_d;
		ok_q   <= ok_d;
	end

	always_comb begin
		st_d    = st_q;
		i_d     = i_q;
		j_d     = j_q;
		pos_d   = pos_q;
		best_d  = best_q;
		ok_d    = ok_q;
		diag_wr = '0;
		done    = 1'b0;
		fin     = 1'b0;
		best_e  = best_q;
		stop    = 1'b0;

		case (st_q)
			lcsd_pkg::SW_IDLE: begin
				if (start) begin
					best_d = '0;
					i_d    = '0;
					j_d    = '0;
					pos_d  = '0;
					st_d   = (job.m != '0) ? lcsd_pkg::SW_TBL : lcsd_pkg::SW_DONE;
				end
			end
			lcsd_pkg::SW_TBL: begin
				ok_d = sym_ok;
				st_d = lcsd_pkg::SW_EVAL;
			end
			lcsd_pkg::SW_EVAL: begin
				if (least > lcsd_pkg::POS_W'(job.n)) begin
					fin = 1'b1;
				end else begin
					diag_wr.en   = 1'b1;
					diag_wr.addr = len;
					diag_wr.data = least;
					pos_d        = least;
					if (len_p1 > best_q) begin
						best_e = len_p1;
					end
					best_d = best_e;
					if (lcsd_pkg::CNT_W'(j_q) + lcsd_pkg::CNT_W'(1) < job.m) begin
						j_d  = j_q + lcsd_pkg::ADDR_W'(1);
						st_d = lcsd_pkg::SW_TBL;
					end else begin
						fin = 1'b1;
					end
				end
				// end of a diagonal: stop when the rest of A cannot beat best or no diagonal is left
				if (fin) begin
					stop = (i_rem < best_e) || (i_p1c >= job.m);
					if (stop) begin
						st_d = lcsd_pkg::SW_DONE;
					end else begin
						i_d   = i_q + lcsd_pkg::ADDR_W'(1);
						j_d   = i_q + lcsd_pkg::ADDR_W'(1);
						pos_d = '0;
						st_d  = lcsd_pkg::SW_TBL;
					end
				end
			end
			lcsd_pkg::SW_DONE: begin
				done = 1'b1;
				st_d = lcsd_pkg::SW_IDLE;
			end
			default: begin
				st_d = lcsd_pkg::SW_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/lcs_length_diagonal_top.sv
// Top level of the diagonal LCS length engine: loads, control and result register.
//
// Channel   Dir  Handshake           Payload
// -------   ---  ------------------  --------------------------------------------
// s_*       in   s_tvalid/s_tready   s_tuser[1:0] opcode, s_tdata[4:0] symbol
// m_*       out  m_tvalid/m_tready   m_tdata[8:0] lcs_length, m_tuser[0] load_overflow
// cfg_*     in   cfg_we              cfg_wdata[4:0] alphabet_size
//
// Load items are accepted back to back while no compute is running.
// A compute item holds s_tready low while the engine clears the diagonal store, runs
// the backward table fill for each symbol of the active alphabet (one B read per
// entry), runs the sweep, where each diagonal step reads the table and diagonal RAMs
// and then compares and writes, and finally passes through build done, sweep done
// and result load.
// Reset clears counts, overflow flag and the result valid flag, sets the alphabet
// register to 16 and resets all sequencers; the RAMs need no clearing since every
// entry read is written by the same compute.
// A result waiting on m_tready does not block loads; the next compute runs and then
// waits for the result register to drain.
module lcs_length_diagonal_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,   // alphabet_size
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // [4:0] symbol, [7:5] zero
	input  logic [1:0]  s_tuser,     // [1:0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,     // [8:0] lcs_length, [15:9] zero
	output logic [0:0]  m_tuser      // [0] load_overflow
);

	lcsd_pkg::top_state_t st_q, st_d;

	logic [lcsd_pkg::CFG_W-1:0] alpha_q;
	logic [lcsd_pkg::CNT_W-1:0] a_cnt_q, b_cnt_q;
	logic                       ovf_q;
	logic                       out_valid_q, out_ovf_q;
	logic [lcsd_pkg::OUT_LEN_W-1:0] out_len_q;

	logic                       accept, a_full, b_full, a_we, b_we;
	logic                       bld_start, swp_start, out_load;
	lcsd_pkg::opcode_t          op;
	logic [lcsd_pkg::SYM_W-1:0] sym;
	lcsd_pkg::job_t             job;

	logic                        bld_done, swp_done;
	logic [lcsd_pkg::ADDR_W-1:0] b_raddr, a_raddr, diag_raddr;
	logic [lcsd_pkg::SYM_W-1:0]  a_rdata, b_rdata;
	logic [lcsd_pkg::TBL_AW-1:0] tbl_raddr;
	logic [lcsd_pkg::POS_W-1:0]  tbl_rdata, diag_rdata;
	lcsd_pkg::tbl_wr_t           tbl_wr;
	lcsd_pkg::diag_wr_t          bld_diag_wr, swp_diag_wr, diag_wr;
	logic [lcsd_pkg::CNT_W-1:0]  best;
	logic [lcsd_pkg::CNT_W+lcsd_pkg::OUT_LEN_W-1:0] best_wide;

	assign op     = lcsd_pkg::opcode_t'(s_tuser);
	assign sym    = s_tdata[lcsd_pkg::SYM_W-1:0];
	assign accept = s_tvalid && s_tready;
	assign a_full = (a_cnt_q >= lcsd_pkg::CNT_W'(lcsd_pkg::MAX_LEN));
	assign b_full = (b_cnt_q >= lcsd_pkg::CNT_W'(lcsd_pkg::MAX_LEN));
	assign a_we   = accept && (op == lcsd_pkg::OP_LOAD_A) && !a_full;
	assign b_we   = accept && (op == lcsd_pkg::OP_LOAD_B) && !b_full;

	// counts hold still for the whole compute; the user must hold the alphabet, the block does not enforce it
	assign job.m = a_cnt_q;
	assign job.n = b_cnt_q;
	assign job.alpha = (lcsd_pkg::CMP_W'(alpha_q) < lcsd_pkg::CMP_W'(lcsd_pkg::MAX_ALPHABET)) ?
	                   lcsd_pkg::AC_W'(alpha_q) : lcsd_pkg::AC_W'(lcsd_pkg::MAX_ALPHABET);

	assign diag_wr   = bld_diag_wr.en ? bld_diag_wr : swp_diag_wr;
	assign best_wide = {{lcsd_pkg::OUT_LEN_W{1'b0}}, best};

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = {{(16 - lcsd_pkg::OUT_LEN_W){1'b0}}, out_len_q};
	assign m_tuser[0] = out_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= lcsd_pkg::TOP_IDLE;
			alpha_q     <= lcsd_pkg::CFG_W'(16);
			a_cnt_q     <= '0;
			b_cnt_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				alpha_q <= cfg_wdata;
			end
			if (a_we) begin
				a_cnt_q <= a_cnt_q + lcsd_pkg::CNT_W'(1);
			end
			if (b_we) begin
				b_cnt_q <= b_cnt_q + lcsd_pkg::CNT_W'(1);
			end
			if (accept && (((op == lcsd_pkg::OP_LOAD_A) && a_full) ||
			               ((op == lcsd_pkg::OP_LOAD_B) && b_full))) begin
				ovf_q <= 1'b1;
			end
			if (out_load) begin
				a_cnt_q     <= '0;
				b_cnt_q     <= '0;
				ovf_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_len_q <= best_wide[lcsd_pkg::OUT_LEN_W-1:0];
			out_ovf_q <= ovf_q;
		end
	end

	always_comb begin
		st_d      = st_q;
		s_tready  = 1'b0;
		bld_start = 1'b0;
		swp_start = 1'b0;
		out_load  = 1'b0;
		case (st_q)
			lcsd_pkg::TOP_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && (op == lcsd_pkg::OP_COMPUTE)) begin
					bld_start = 1'b1;
					st_d      = lcsd_pkg::TOP_BUILD;
				end
			end
			lcsd_pkg::TOP_BUILD: begin
				if (bld_done) begin
					swp_start = 1'b1;
					st_d      = lcsd_pkg::TOP_SWEEP;
				end
			end
			lcsd_pkg::TOP_SWEEP: begin
				if (swp_done) begin
					st_d = lcsd_pkg::TOP_DONE;
				end
			end
			lcsd_pkg::TOP_DONE: begin
				// hold until the result register is free
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					st_d     = lcsd_pkg::TOP_IDLE;
				end
			end
			default: begin
				st_d = lcsd_pkg::TOP_IDLE;
			end
		endcase
	end

	lcsd_ram #(.WIDTH(lcsd_pkg::SYM_W), .DEPTH(lcsd_pkg::MAX_LEN)) u_seq_a (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_cnt_q[lcsd_pkg::ADDR_W-1:0]),
		.wdata (sym),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	lcsd_ram #(.WIDTH(lcsd_pkg::SYM_W), .DEPTH(lcsd_pkg::MAX_LEN)) u_seq_b (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_cnt_q[lcsd_pkg::ADDR_W-1:0]),
		.wdata (sym),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	lcsd_ram #(.WIDTH(lcsd_pkg::POS_W), .DEPTH(lcsd_pkg::TBL_DEPTH)) u_next_tbl (
		.clk   (clk),
		.we    (tbl_wr.en),
		.waddr (tbl_wr.addr),
		.wdata (tbl_wr.data),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	lcsd_ram #(.WIDTH(lcsd_pkg::POS_W), .DEPTH(lcsd_pkg::MAX_LEN)) u_diag (
		.clk   (clk),
		.we    (diag_wr.en),
		.waddr (diag_wr.addr),
		.wdata (diag_wr.data),
		.raddr (diag_raddr),
		.rdata (diag_rdata)
	);

	lcsd_build u_build (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (bld_start),
		.job     (job),
		.b_rdata (b_rdata),
		.b_raddr (b_raddr),
		.tbl_wr  (tbl_wr),
		.diag_wr (bld_diag_wr),
		.done    (bld_done)
	);

	lcsd_sweep u_sweep (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (swp_start),
		.job        (job),
		.a_rdata    (a_rdata),
		.tbl_rdata  (tbl_rdata),
		.diag_rdata (diag_rdata),
		.a_raddr    (a_raddr),
		.tbl_raddr  (tbl_raddr),
		.diag_raddr (diag_raddr),
		.diag_wr    (swp_diag_wr),
		.done       (swp_done),
		.best       (best)
	);

endmodule
